[rtl/pngu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared constants, types and codes of the PNG scanline unfilter unit.
// ----------------------------------------------------------------------------
package pngu_pkg;

   localparam int MAX_ROW_BYTES = 8192;
   localparam int ROW_ADDR_W    = $clog2(MAX_ROW_BYTES);
   localparam int COL_W         = ROW_ADDR_W + 1;

   localparam int BYTE_W        = 8;
   localparam int BPP_W         = 3;
   localparam int ROW_BYTES_W   = 14;
   localparam int ROW_COUNT_W   = 16;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 16;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = QUEUE_PTR_W + 1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_BYTES       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_COUNT       = 2'd2;

   localparam logic [BPP_W-1:0]       BPP_RESET       = 3'd4;
   localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 14'd4;
   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 16'd1;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // one queued unit of work for the back end
   typedef struct packed {
      logic [BYTE_W-1:0]     data;
      filter_type            filt;
      logic                  bad;
      logic                  first_col;
      logic                  top_row;
      logic                  eor;
      logic                  eoi;
      logic [ROW_ADDR_W-1:0] col;
   } work_type;

endpackage

[rtl/pngu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pngu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pngu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_front
// Accepts stream bytes, tracks filter bytes, columns and rows, and queues
// data bytes and bad filter events for the back end.
// ----------------------------------------------------------------------------
module pngu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pngu_pkg::BYTE_W-1:0]         req_byte,
   input  logic [pngu_pkg::ROW_BYTES_W-1:0]    row_bytes,
   input  logic [pngu_pkg::ROW_COUNT_W-1:0]    row_count,
   input  logic                                queue_full,
   output logic                                push,
   output pngu_pkg::work_type                  push_work
);

   logic                                expect_ff, expect_in;
   logic [pngu_pkg::ROW_ADDR_W-1:0]     column_ff, column_in;
   logic [pngu_pkg::ROW_COUNT_W-1:0]    row_ff, row_in;
   pngu_pkg::filter_type                filt_ff, filt_in;

   logic                                accept;
   logic                                bad;
   logic [pngu_pkg::COL_W-1:0]          rb_eff;
   logic [pngu_pkg::ROW_COUNT_W-1:0]    rc_eff;
   logic                                eor;
   logic                                eoi;

   always_comb begin
      if (row_bytes == '0) begin
         rb_eff = pngu_pkg::COL_W'(1);
      end else if (32'(row_bytes) > pngu_pkg::MAX_ROW_BYTES) begin
         rb_eff = pngu_pkg::COL_W'(pngu_pkg::MAX_ROW_BYTES);
      end else begin
         rb_eff = pngu_pkg::COL_W'(row_bytes);
      end
      rc_eff = (row_count == '0) ? pngu_pkg::ROW_COUNT_W'(1) : row_count;
   end

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign bad       = req_byte > pngu_pkg::BYTE_W'(pngu_pkg::FILT_PAETH);
   assign eor       = ({1'b0, column_ff} + pngu_pkg::COL_W'(1)) >= rb_eff;
   assign eoi       = eor && (({1'b0, row_ff} + 17'd1) >= {1'b0, rc_eff});

   always_comb begin
      expect_in = expect_ff;
      column_in = column_ff;
      row_in    = row_ff;
      filt_in   = filt_ff;
      push      = 1'b0;

      push_work.data      = req_byte;
      push_work.filt      = filt_ff;
      push_work.bad       = 1'b0;
      push_work.first_col = (column_ff == '0);
      push_work.top_row   = (row_ff == '0);
      push_work.eor       = eor;
      push_work.eoi       = eoi;
      push_work.col       = column_ff;

      if (accept) begin
         if (expect_ff) begin
            expect_in = 1'b0;
            column_in = '0;
            if (bad) begin
               filt_in       = pngu_pkg::FILT_NONE;
               push          = 1'b1;
               push_work.bad = 1'b1;
               push_work.eor = 1'b0;
               push_work.eoi = 1'b0;
               push_work.data = '0;
            end else begin
               filt_in = pngu_pkg::filter_type'(req_byte[2:0]);
            end
         end else begin
            push = 1'b1;
            if (eor) begin
               column_in = '0;
               expect_in = 1'b1;
               row_in    = eoi ? '0 : row_ff + pngu_pkg::ROW_COUNT_W'(1);
            end else begin
               column_in = column_ff + pngu_pkg::ROW_ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 1'b1;
         column_ff <= '0;
         row_ff    <= '0;
         filt_ff   <= pngu_pkg::FILT_NONE;
      end else begin
         expect_ff <= expect_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         filt_ff   <= filt_in;
      end
   end

endmodule

[rtl/pngu_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_fifo
// Short work queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pngu_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pngu_pkg::work_type push_work,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output pngu_pkg::work_type pop_work
);

   pngu_pkg::work_type                 entry_ff [pngu_pkg::QUEUE_DEPTH];
   logic [pngu_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pngu_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pngu_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == pngu_pkg::QUEUE_CNT_W'(pngu_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_work = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + pngu_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + pngu_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + pngu_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pngu_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule

[rtl/pngu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_back
// Reads the line store, rebuilds each data byte with its row filter,
// writes the byte back for the next row and holds the result register.
// ----------------------------------------------------------------------------
module pngu_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pngu_pkg::BPP_W-1:0]        bytes_per_pixel,
   input  logic                              queue_valid,
   input  pngu_pkg::work_type                queue_work,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pngu_pkg::BYTE_W-1:0]       rsp_pixel,
   output logic                              rsp_bad,
   output logic                              rsp_eor,
   output logic                              rsp_eoi
);

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [9:0] pa;
      logic signed [9:0] pb;
      logic signed [9:0] pc;
      pa = $signed({2'b00, b}) - $signed({2'b00, c});
      pb = $signed({2'b00, a}) - $signed({2'b00, c});
      pc = pa + pb;
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) begin
         paeth = a;
      end else if (pb <= pc) begin
         paeth = b;
      end else begin
         paeth = c;
      end
   endfunction

   // stage holding the entry whose line store read is in flight
   logic                              a_valid_ff, a_valid_in;
   pngu_pkg::work_type                a_work_ff;
   logic                              fwd_ff;
   logic [pngu_pkg::BYTE_W-1:0]       fwd_data_ff;
   logic [31:0]                       left_ff, left_in;
   logic [31:0]                       corner_ff, corner_in;
   logic                              out_valid_ff, out_valid_in;
   logic [pngu_pkg::BYTE_W-1:0]       out_pixel_ff;
   logic                              out_bad_ff;
   logic                              out_eor_ff;
   logic                              out_eoi_ff;

   logic [pngu_pkg::BYTE_W-1:0]       ram_q;
   logic                              a_adv;
   logic                              wr_en;
   logic                              fwd_hit;
   logic [1:0]                        sel;
   logic [pngu_pkg::BYTE_W-1:0]       above;
   logic [pngu_pkg::BYTE_W-1:0]       left;
   logic [pngu_pkg::BYTE_W-1:0]       corner;
   logic [pngu_pkg::BYTE_W-1:0]       pred;
   logic [pngu_pkg::BYTE_W:0]         sum9;
   logic [pngu_pkg::BYTE_W-1:0]       val;

   pngu_ram #(
      .WIDTH (pngu_pkg::BYTE_W),
      .DEPTH (pngu_pkg::MAX_ROW_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (a_work_ff.col),
      .wr_data (val),
      .rd_en   (pop),
      .rd_addr (queue_work.col),
      .rd_data (ram_q)
   );

   // clamp to 1..4 and turn into a byte lane
   always_comb begin
      if (bytes_per_pixel == '0) begin
         sel = 2'd0;
      end else if (bytes_per_pixel > 3'd4) begin
         sel = 2'd3;
      end else begin
         sel = 2'(bytes_per_pixel - 3'd1);
      end
   end

   assign a_adv   = a_valid_ff && (!out_valid_ff || rsp_ready);
   assign pop     = queue_valid && (!a_valid_ff || a_adv);
   assign wr_en   = a_adv && !a_work_ff.bad;
   assign fwd_hit = wr_en && (a_work_ff.col == queue_work.col);

   always_comb begin
      above  = a_work_ff.top_row ? '0 : (fwd_ff ? fwd_data_ff : ram_q);
      left   = a_work_ff.first_col ? '0 : left_ff[8*sel +: 8];
      corner = a_work_ff.first_col ? '0 : corner_ff[8*sel +: 8];
      sum9   = {1'b0, left} + {1'b0, above};
      unique case (a_work_ff.filt)
         pngu_pkg::FILT_SUB:   pred = left;
         pngu_pkg::FILT_UP:    pred = above;
         pngu_pkg::FILT_AVG:   pred = sum9[8:1];
         pngu_pkg::FILT_PAETH: pred = paeth(left, above, corner);
         default:              pred = '0;
      endcase
      val = a_work_ff.bad ? '0 : a_work_ff.data + pred;
   end

   always_comb begin
      a_valid_in   = pop ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);
      out_valid_in = a_adv ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      left_in      = left_ff;
      corner_in    = corner_ff;
      if (wr_en) begin
         left_in   = a_work_ff.first_col ? {24'd0, val}   : {left_ff[23:0], val};
         corner_in = a_work_ff.first_col ? {24'd0, above} : {corner_ff[23:0], above};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         corner_ff    <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
         corner_ff    <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_work_ff   <= queue_work;
         fwd_ff      <= fwd_hit;
         fwd_data_ff <= val;
      end
      if (a_adv) begin
         out_pixel_ff <= val;
         out_bad_ff   <= a_work_ff.bad;
         out_eor_ff   <= a_work_ff.eor;
         out_eoi_ff   <= a_work_ff.eoi;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pixel = out_pixel_ff;
   assign rsp_bad   = out_bad_ff;
   assign rsp_eor   = out_eor_ff;
   assign rsp_eoi   = out_eoi_ff;

endmodule

[rtl/png_scanline_unfilter_unit.sv]
`timescale 1ns / 1ps
// path: a taken data byte passes the work queue, the read stage and the result register
// throughput: one request per cycle while results are taken, set by the left-byte
// feedback and one line store read plus one write per cycle
// filter type requests give no result unless the type is above four
// reset: synchronous; registers return to 4 / 4 / 1, a new image awaits its filter byte
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// PNG scanline reconstruction of 8-bit samples with a one-row line store.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // stream_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // pixel_value
   output logic                                rsp_tlast,   // end_of_row
   output logic [1:0]                          rsp_tuser,   // bad_filter, end_of_image
   input  logic                                csr_we,
   input  logic [pngu_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pngu_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [pngu_pkg::BPP_W-1:0]       bpp_ff;
   logic [pngu_pkg::ROW_BYTES_W-1:0] row_bytes_ff;
   logic [pngu_pkg::ROW_COUNT_W-1:0] row_count_ff;

   logic                             queue_full;
   logic                             push;
   pngu_pkg::work_type               push_work;
   logic                             pop;
   logic                             queue_valid;
   pngu_pkg::work_type               queue_work;
   logic                             rsp_bad;
   logic                             rsp_eoi;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= pngu_pkg::BPP_RESET;
         row_bytes_ff <= pngu_pkg::ROW_BYTES_RESET;
         row_count_ff <= pngu_pkg::ROW_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            pngu_pkg::CSR_BYTES_PER_PIXEL: bpp_ff <= csr_wdata[pngu_pkg::BPP_W-1:0];
            pngu_pkg::CSR_ROW_BYTES: row_bytes_ff <= csr_wdata[pngu_pkg::ROW_BYTES_W-1:0];
            pngu_pkg::CSR_ROW_COUNT: row_count_ff <= csr_wdata[pngu_pkg::ROW_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   pngu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_byte   (req_tdata),
      .row_bytes  (row_bytes_ff),
      .row_count  (row_count_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_work  (push_work)
   );

   pngu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_work (push_work),
      .full      (queue_full),
      .pop       (pop),
      .valid     (queue_valid),
      .pop_work  (queue_work)
   );

   pngu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .bytes_per_pixel (bpp_ff),
      .queue_valid     (queue_valid),
      .queue_work      (queue_work),
      .pop             (pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_pixel       (rsp_tdata),
      .rsp_bad         (rsp_bad),
      .rsp_eor         (rsp_tlast),
      .rsp_eoi         (rsp_eoi)
   );

   assign rsp_tuser = {rsp_eoi, rsp_bad};

endmodule

[verif/png_unfilter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_unfilter_checker
// Watches the request, result and register ports of the scanline unfilter
// unit. It rebuilds every accepted data byte with its own copy of the filter
// state and line store, queues the expected pixel, and compares each accepted
// result with the oldest queued pixel field by field.
// ----------------------------------------------------------------------------
module png_unfilter_checker
   import pngu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,    // stream_byte
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [7:0]            rsp_tdata,    // pixel_value
   input  logic                  rsp_tlast,    // end_of_row
   input  logic [1:0]            rsp_tuser,    // bad_filter, end_of_image
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    awaiting_results,
   output int                    request_count,
   output int                    result_count,
   output int                    bad_rows,
   output int                    images_done
);

   localparam int              MAX_BPP      = 4;
   localparam int              SHOWN_ERRORS = 10;
   localparam logic [BYTE_W-1:0] TOP_FILTER = BYTE_W'(FILT_PAETH);

   typedef struct packed {
      logic [7:0] pixel;
      logic       bad;
      logic       eor;
      logic       eoi;
   } pixel_result;

   pixel_result pending_pixels[$];

   logic [BPP_W-1:0]       cfg_bpp;
   logic [ROW_BYTES_W-1:0] cfg_row_bytes;
   logic [ROW_COUNT_W-1:0] cfg_row_count;

   logic [7:0]  line_above [MAX_ROW_BYTES];
   logic [31:0] recent_pixels;
   logic [31:0] recent_above;
   int          col_pos;
   logic [15:0] row_num;
   filter_type  cur_filter;
   logic        awaiting_type;

   function automatic logic [7:0] paeth_choose(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int p, pa, pb, pc;
      p  = int'(a) + int'(b) - int'(c);
      pa = p > int'(a) ? p - int'(a) : int'(a) - p;
      pb = p > int'(b) ? p - int'(b) : int'(b) - p;
      pc = p > int'(c) ? p - int'(c) : int'(c) - p;
      if (pa <= pb && pa <= pc)
         return a;
      if (pb <= pc)
         return b;
      return c;
   endfunction

   task automatic rebuild_byte(input logic [7:0] b);
      int          bpp, rb, rc, idx;
      logic [7:0]  left, above, corner, pred, val;
      logic        eor, eoi;
      pixel_result r;
      if (awaiting_type) begin
         awaiting_type = 1'b0;
         col_pos       = 0;
         recent_pixels = '0;
         recent_above  = '0;
         if (b > TOP_FILTER) begin
            cur_filter = FILT_NONE;
            r = '{pixel: 8'h00, bad: 1'b1, eor: 1'b0, eoi: 1'b0};
            pending_pixels.push_back(r);
         end else begin
            cur_filter = filter_type'(b[2:0]);
         end
         return;
      end
      bpp = cfg_bpp == 0 ? 1 : (cfg_bpp > MAX_BPP ? MAX_BPP : int'(cfg_bpp));
      rb  = cfg_row_bytes == 0 ? 1 :
            (cfg_row_bytes > MAX_ROW_BYTES ? MAX_ROW_BYTES : int'(cfg_row_bytes));
      rc  = cfg_row_count == 0 ? 1 : int'(cfg_row_count);
      idx = col_pos < MAX_ROW_BYTES ? col_pos : MAX_ROW_BYTES - 1;

      left   = 8'(recent_pixels >> (8 * (bpp - 1)));
      corner = 8'(recent_above >> (8 * (bpp - 1)));
      above  = row_num == 0 ? 8'h00 : line_above[idx];
      case (cur_filter)
         FILT_SUB:   pred = left;
         FILT_UP:    pred = above;
         FILT_AVG:   pred = 8'((9'(left) + 9'(above)) >> 1);
         FILT_PAETH: pred = paeth_choose(left, above, corner);
         default:    pred = 8'h00;
      endcase
      val = b + pred;

      line_above[idx] = val;
      recent_pixels   = {recent_pixels[23:0], val};
      recent_above    = {recent_above[23:0], above};

      eor = col_pos + 1 >= rb;
      eoi = eor && (int'(row_num) + 1 >= rc);
      if (eor) begin
         col_pos       = 0;
         awaiting_type = 1'b1;
         row_num       = eoi ? 16'd0 : row_num + 16'd1;
      end else begin
         col_pos++;
      end
      r = '{pixel: val, bad: 1'b0, eor: eor, eoi: eoi};
      pending_pixels.push_back(r);
   endtask

   task automatic note_failure(input string what);
      if (mismatches < SHOWN_ERRORS)
         $display("%0t: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      pixel_result got, want;
      if (reset) begin
         cfg_bpp          = BPP_RESET;
         cfg_row_bytes    = ROW_BYTES_RESET;
         cfg_row_count    = ROW_COUNT_RESET;
         recent_pixels    = '0;
         recent_above     = '0;
         col_pos          = 0;
         row_num          = '0;
         cur_filter       = FILT_NONE;
         awaiting_type    = 1'b1;
         pending_pixels.delete();
         mismatches       = 0;
         request_count    = 0;
         result_count     = 0;
         bad_rows         = 0;
         images_done      = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_BYTES_PER_PIXEL: cfg_bpp       = csr_wdata[BPP_W-1:0];
               CSR_ROW_BYTES:       cfg_row_bytes = csr_wdata[ROW_BYTES_W-1:0];
               CSR_ROW_COUNT:       cfg_row_count = csr_wdata[ROW_COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            request_count++;
            rebuild_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{pixel: rsp_tdata, bad: rsp_tuser[0], eor: rsp_tlast, eoi: rsp_tuser[1]};
            result_count++;
            if (got.bad)
               bad_rows++;
            if (got.eoi)
               images_done++;
            if (pending_pixels.size() == 0) begin
               note_failure($sformatf("unexpected result pixel %02h bad %0b eor %0b eoi %0b",
                                      got.pixel, got.bad, got.eor, got.eoi));
            end else begin
               want = pending_pixels.pop_front();
               if (got !== want)
                  note_failure($sformatf({"result mismatch: expected pixel %02h bad %0b ",
                                          "eor %0b eoi %0b, got pixel %02h bad %0b ",
                                          "eor %0b eoi %0b"},
                                         want.pixel, want.bad, want.eor, want.eoi,
                                         got.pixel, got.bad, got.eor, got.eoi));
            end
         end
      end
      awaiting_results = pending_pixels.size();
   end

endmodule

[verif/tb_png_scanline_unfilter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter_unit
// Feeds filtered scanline streams into the unfilter unit: a short directed
// image with every filter and a bad filter byte, register extremes, a row
// longer than the line store allows, a tall image cut short mid-row, a
// back-to-back stream, then random images. Both channels otherwise idle at
// random; the result side also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter_unit;
   import pngu_pkg::*;

   localparam int         CYCLE_LIMIT       = 400000;
   localparam int         RANDOM_ITEMS      = 900;
   localparam int         IDLE_PCT          = 26;
   localparam int         STALL_CYCLES      = 250;
   localparam int         DRAIN_CYCLES      = 8;
   localparam int         LONG_ROW_PART     = 40;
   localparam logic [7:0] LOWEST_BAD_FILTER = 8'd5;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [7:0]            req_tdata  = '0;     // stream_byte
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [7:0]            rsp_tdata;           // pixel_value
   logic                  rsp_tlast;           // end_of_row
   logic [1:0]            rsp_tuser;           // bad_filter, end_of_image

   int mismatches, awaiting_results, request_count, result_count, bad_rows, images_done;

   logic [7:0] stream_q[$];
   int         idle_pct      = IDLE_PCT;
   logic       rsp_hold      = 1'b0;
   bit         stall_armed   = 1'b0;
   int         cycle_count   = 0;
   int         settings_used = 0;
   int         longest_row   = 0;
   int         random_items  = 0;

   png_scanline_unfilter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   png_unfilter_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .rsp_tuser        (rsp_tuser),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .awaiting_results (awaiting_results),
      .request_count    (request_count),
      .result_count     (result_count),
      .bad_rows         (bad_rows),
      .images_done      (images_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaiting_results);
      $display("== FAIL ==");
      $finish;
   end

   // request side: hold an offered byte until taken, idle at random otherwise
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            void'(stream_q.pop_front());
         if (!req_tvalid || req_tready) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= stream_q[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= idle_pct);
   end

   // long result back-pressure so the unit fills up and stops taking requests
   initial begin
      wait (stall_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic int eff_row_bytes(logic [15:0] raw);
      logic [ROW_BYTES_W-1:0] rb;
      rb = raw[ROW_BYTES_W-1:0];
      if (rb == 0)
         return 1;
      return rb > MAX_ROW_BYTES ? MAX_ROW_BYTES : int'(rb);
   endfunction

   function automatic int eff_row_count(logic [15:0] raw);
      return raw == 0 ? 1 : int'(raw);
   endfunction

   function automatic logic [7:0] pick_filter();
      if ($urandom_range(99) < 10)
         return $urandom_range(1) ? LOWEST_BAD_FILTER
                                  : 8'($urandom_range(255, int'(LOWEST_BAD_FILTER)));
      return 8'($urandom_range(int'(FILT_PAETH), int'(FILT_NONE)));
   endfunction

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_image(input logic [15:0] bpp_w, input logic [15:0] rb_w,
                            input logic [15:0] rc_w);
      write_reg(CSR_BYTES_PER_PIXEL, bpp_w);
      write_reg(CSR_ROW_BYTES, rb_w);
      write_reg(CSR_ROW_COUNT, rc_w);
      settings_used++;
      if (eff_row_bytes(rb_w) > longest_row)
         longest_row = eff_row_bytes(rb_w);
   endtask

   task automatic queue_rows(input int rows, input int rb);
      @(negedge clock);
      for (int r = 0; r < rows; r++) begin
         stream_q.push_back(pick_filter());
         for (int c = 0; c < rb; c++)
            stream_q.push_back(8'($urandom));
      end
   endtask

   // all requests taken and all results seen, then let the pipeline settle
   task automatic wait_idle();
      do
         @(negedge clock);
      while (stream_q.size() != 0 || req_tvalid || awaiting_results != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int          rb_eff, rc_eff, n_rows;
      logic [15:0] bpp_w, rb_w, rc_w;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // one image of six 3-byte rows: each filter, carry and 9-bit average, bad type
      set_image(16'd1, 16'd3, 16'd6);
      @(negedge clock);
      stream_q = {8'(FILT_NONE),  8'h00, 8'hFF, 8'h80,
                  8'(FILT_SUB),   8'hFF, 8'h01, 8'hFE,
                  8'(FILT_UP),    8'hFF, 8'h80, 8'h01,
                  8'(FILT_AVG),   8'hFF, 8'hFF, 8'hFF,
                  8'(FILT_PAETH), 8'h7F, 8'h00, 8'hFF,
                  8'hFF,          8'hAA, 8'h55, 8'h00};
      wait_idle();

      stall_armed = 1'b1;
      set_image(16'd3, 16'd7, 16'd5);
      queue_rows(15, 7);
      wait_idle();

      // zero pixel distance and zero row length act as one
      set_image(16'hFFF8, 16'd0, 16'd9);
      queue_rows(18, eff_row_bytes(16'd0));
      wait_idle();

      // row length beyond the line store clamps to full width, so a long row
      // keeps going until the row length is brought down mid-row
      write_reg(CSR_BYTES_PER_PIXEL, 16'd7);
      write_reg(CSR_ROW_BYTES, 16'hFFFF);
      write_reg(CSR_ROW_COUNT, 16'd2);
      settings_used++;
      @(negedge clock);
      stream_q.push_back(pick_filter());
      for (int c = 0; c < LONG_ROW_PART; c++)
         stream_q.push_back(8'($urandom));
      wait_idle();
      write_reg(CSR_ROW_BYTES, 16'(LONG_ROW_PART + 1));
      @(negedge clock);
      stream_q.push_back(8'($urandom));
      wait_idle();

      // tallest image, cut short mid-row by register writes
      set_image(16'd2, 16'd2, 16'hFFFF);
      queue_rows(40, 2);
      stream_q.push_back(8'(FILT_AVG));
      stream_q.push_back(8'($urandom));
      wait_idle();
      write_reg(CSR_BYTES_PER_PIXEL, 16'd1);
      write_reg(CSR_ROW_BYTES, 16'd1);
      write_reg(CSR_ROW_COUNT, 16'd0);
      @(negedge clock);
      stream_q.push_back(8'($urandom));
      wait_idle();

      // back-to-back stream with no idling on either side
      @(negedge clock);
      idle_pct = 0;
      set_image(16'd4, 16'd24, 16'd6);
      queue_rows(12, 24);
      wait_idle();
      @(negedge clock);
      idle_pct = IDLE_PCT;

      while (random_items < RANDOM_ITEMS) begin
         bpp_w  = 16'($urandom_range(7));
         rb_w   = $urandom_range(9) < 2 ? 16'($urandom_range(64, 13))
                                        : 16'($urandom_range(12, 1));
         rc_w   = 16'($urandom_range(6));
         rb_eff = eff_row_bytes(rb_w);
         rc_eff = eff_row_count(rc_w);
         n_rows = rc_eff * $urandom_range(2, 1);
         set_image(bpp_w, rb_w, rc_w);
         queue_rows(n_rows, rb_eff);
         random_items += n_rows * (rb_eff + 1);
         wait_idle();
      end

      $display("covered %0d requests and %0d results, %0d bad filter rows, %0d images",
               request_count, result_count, bad_rows, images_done);
      $display("over %0d register settings, rows up to %0d bytes, %0d mismatches",
               settings_used, longest_row, mismatches);
      if (mismatches == 0 && awaiting_results == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
